FILE: rtl/core/dlts_pkg.sv
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants of the delta-list task scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int READY_DEPTH_DEF = 16;

	localparam int OP_W     = 2;
	localparam int TAG_W    = 8;
	localparam int TICK_W   = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_TICK     = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_SCAN,
		S_SH_RD,
		S_SH_WR,
		S_INS_PUT,
		S_INS_FIX,
		S_TK_RD,
		S_TK_WR,
		S_DS_START,
		S_MV_RD,
		S_MV,
		S_POP,
		S_POP2,
		S_DONE
	} sch_state_t;

	// one table entry
	typedef struct packed {
		logic [TICK_W-1:0] delta;
		logic [TICK_W-1:0] period;
		logic [TAG_W-1:0]  tag;
	} tab_ent_t;

	// one ready fifo entry
	typedef struct packed {
		logic [TICK_W-1:0] period;
		logic [TAG_W-1:0]  tag;
	} rdy_ent_t;

endpackage

FILE: rtl/core/dlts_req_if.sv
// ----------------------------------------------------------------------------
// dlts_req_if
// Request channel: one operation per beat.
// ----------------------------------------------------------------------------
interface dlts_req_if
	import dlts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [TAG_W-1:0]  task_tag;
	logic [TICK_W-1:0] delay_ticks;
	logic [TICK_W-1:0] period_ticks;

	modport source (output valid, opcode, task_tag, delay_ticks, period_ticks, input ready);
	modport sink   (input valid, opcode, task_tag, delay_ticks, period_ticks, output ready);
endinterface

FILE: rtl/core/dlts_rsp_if.sv
// ----------------------------------------------------------------------------
// dlts_rsp_if
// Response channel: one result per beat.
// ----------------------------------------------------------------------------
interface dlts_rsp_if
	import dlts_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                run_valid;
	logic [TAG_W-1:0]    run_tag;

	modport source (output valid, status, run_valid, run_tag, input ready);
	modport sink   (input valid, status, run_valid, run_tag, output ready);
endinterface

FILE: rtl/core/delta_list_task_scheduler_core.sv
// Operations: tick reads the head entry and writes it back decremented (no write on an
// empty table); add scans N entries, shifts S entries up one at a time, writes the new
// entry and fixes the delta of the entry after it; dispatch moves due head entries into
// the ready fifo, pops one and re-adds the popped task when it repeats. Only one
// operation runs at a time, paced by its walk over the single table memory.
// Reset: asynchronous, clears counts, pointers, due flag and output valid;
// memories are not cleared, entries are read only below their counts.
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_core
// Delta-time sorted timer list with ready fifo; each memory has a write and a read port.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_core
	import dlts_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int READY_DEPTH = READY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dlts_req_if.sink   req,
	dlts_rsp_if.source rsp
);

	localparam int CAP = (TABLE_DEPTH < READY_DEPTH) ? TABLE_DEPTH : READY_DEPTH;
	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int LW  = $clog2(TABLE_DEPTH + 1);
	localparam int RIW = $clog2(READY_DEPTH);
	localparam int RCW = $clog2(READY_DEPTH + 1);
	localparam int SW  = ((LW > RCW) ? LW : RCW) + 1;

	tab_ent_t tab_mem [TABLE_DEPTH];
	rdy_ent_t rdy_mem [READY_DEPTH];

	sch_state_t state_q, state_d;

	logic [LW-1:0]  cnt_q, idx_q, pos_q, i_q;
	logic [IW-1:0]  hd_q;
	logic           head_due_q, first_q, readd_q;
	logic [RCW-1:0] rcnt_q;
	logic [RIW-1:0] rp_q, wp_q;

	logic [TAG_W-1:0]  tag_q;
	logic [TICK_W-1:0] dly_q, per_q, before_q, nd_q;
	status_t           rs_st_q;
	logic              rs_rv_q;
	logic [TAG_W-1:0]  rs_tag_q;

	logic                ov_q;
	logic [STATUS_W-1:0] o_st_q;
	logic                o_rv_q;
	logic [TAG_W-1:0]    o_tag_q;

	tab_ent_t trd_q, twdata;
	rdy_ent_t frd_q;
	logic     twe;
	logic [IW-1:0] traddr, twaddr;

	logic [TICK_W:0]   cand;
	logic              scan_le, full, out_free, req_beat;
	logic [TICK_W-1:0] new_delta, tick_dec;

	// logical list position to physical slot of the circular table
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [LW-1:0] l);
		logic [LW:0] s;
		s = (LW+1)'(hd) + (LW+1)'(l);
		if (s >= (LW+1)'(TABLE_DEPTH))
			s = s - (LW+1)'(TABLE_DEPTH);
		return s[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] tnext(input logic [IW-1:0] p);
		return (p == IW'(TABLE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [RIW-1:0] rnext(input logic [RIW-1:0] p);
		return (p == RIW'(READY_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// shared compare and subtract datapath
	assign cand      = {1'b0, before_q} + {1'b0, trd_q.delta};
	assign scan_le   = cand <= {1'b0, dly_q};
	assign full      = ((SW'(cnt_q) + SW'(rcnt_q)) >= SW'(CAP))
	                   || (cnt_q >= LW'(TABLE_DEPTH));
	assign new_delta = dly_q - before_q;
	assign tick_dec  = (trd_q.delta != '0) ? trd_q.delta - 1'b1 : '0;
	assign out_free  = !ov_q || rsp.ready;
	assign req_beat  = req.valid && req.ready;

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = ov_q;
	assign rsp.status    = o_st_q;
	assign rsp.run_valid = o_rv_q;
	assign rsp.run_tag   = o_tag_q;

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		traddr  = phys(hd_q, '0);
		twe     = 1'b0;
		twaddr  = phys(hd_q, pos_q);
		twdata  = trd_q;
		case (state_q)
			S_IDLE: begin
				if (req_beat) begin
					case (opcode_t'(req.opcode))
						OP_ADD:      state_d = S_INS_CHK;
						OP_TICK:     state_d = S_TK_RD;
						OP_DISPATCH: state_d = S_DS_START;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_INS_CHK: begin
				if (full)
					state_d = S_DONE;
				else if (cnt_q == '0)
					state_d = S_SH_RD;
				else
					state_d = S_INS_SCAN;
			end
			S_INS_SCAN: begin
				traddr = phys(hd_q, idx_q + 1'b1);
				if (!scan_le || (idx_q + 1'b1 == cnt_q))
					state_d = S_SH_RD;
			end
			S_SH_RD: begin
				traddr = phys(hd_q, i_q - 1'b1);
				state_d = (i_q == pos_q) ? S_INS_PUT : S_SH_WR;
			end
			S_SH_WR: begin
				twe     = 1'b1;
				twaddr  = phys(hd_q, i_q);
				state_d = S_SH_RD;
			end
			S_INS_PUT: begin
				twe     = 1'b1;
				twdata  = '{delta: new_delta, period: per_q, tag: tag_q};
				traddr  = phys(hd_q, pos_q + 1'b1);
				state_d = (pos_q < cnt_q) ? S_INS_FIX : S_DONE;
			end
			S_INS_FIX: begin
				twe          = 1'b1;
				twaddr       = phys(hd_q, pos_q + 1'b1);
				twdata.delta = trd_q.delta - nd_q;
				state_d      = S_DONE;
			end
			S_TK_RD: begin
				state_d = (cnt_q == '0) ? S_DONE : S_TK_WR;
			end
			S_TK_WR: begin
				twe          = 1'b1;
				twaddr       = hd_q;
				twdata.delta = tick_dec;
				state_d      = S_DONE;
			end
			S_DS_START: begin
				if (head_due_q && cnt_q != '0 && rcnt_q < RCW'(READY_DEPTH))
					state_d = S_MV_RD;
				else
					state_d = S_POP;
			end
			S_MV_RD: begin
				if (cnt_q != '0 && rcnt_q < RCW'(READY_DEPTH))
					state_d = S_MV;
				else
					state_d = S_POP;
			end
			S_MV: begin
				state_d = (first_q || trd_q.delta == '0) ? S_MV_RD : S_POP;
			end
			S_POP: begin
				state_d = (rcnt_q == '0) ? S_DONE : S_POP2;
			end
			S_POP2: begin
				state_d = (frd_q.period != '0) ? S_INS_CHK : S_DONE;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (twe)
			tab_mem[twaddr] <= twdata;
		trd_q <= tab_mem[traddr];
	end

	// ready fifo memory
	always_ff @(posedge clk) begin
		if (state_q == S_MV && (first_q || trd_q.delta == '0))
			rdy_mem[wp_q] <= '{period: trd_q.period, tag: trd_q.tag};
		frd_q <= rdy_mem[rp_q];
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			hd_q       <= '0;
			head_due_q <= 1'b0;
			rcnt_q     <= '0;
			rp_q       <= '0;
			wp_q       <= '0;
			first_q    <= 1'b0;
			readd_q    <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_beat)
						readd_q <= 1'b0;
				end
				S_INS_PUT: begin
					cnt_q <= cnt_q + 1'b1;
					if (pos_q == '0)
						head_due_q <= 1'b0;
				end
				S_TK_WR: begin
					if (tick_dec == '0)
						head_due_q <= 1'b1;
				end
				S_DS_START: first_q <= 1'b1;
				S_MV: begin
					if (first_q || trd_q.delta == '0) begin
						wp_q    <= rnext(wp_q);
						rcnt_q  <= rcnt_q + 1'b1;
						hd_q    <= tnext(hd_q);
						cnt_q   <= cnt_q - 1'b1;
						first_q <= 1'b0;
					end
				end
				S_POP: head_due_q <= 1'b0;
				S_POP2: begin
					rp_q    <= rnext(rp_q);
					rcnt_q  <= rcnt_q - 1'b1;
					readd_q <= 1'b1;
				end
				default: ;
			endcase
			if (state_q == S_DONE && out_free)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	// operands, walk indexes and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_beat) begin
					tag_q    <= req.task_tag;
					dly_q    <= req.delay_ticks;
					per_q    <= req.period_ticks;
					rs_st_q  <= ST_OK;
					rs_rv_q  <= 1'b0;
					rs_tag_q <= '0;
				end
			end
			S_INS_CHK: begin
				if (full && !readd_q)
					rs_st_q <= ST_FULL;
				before_q <= '0;
				idx_q    <= '0;
				pos_q    <= '0;
				i_q      <= cnt_q;
			end
			S_INS_SCAN: begin
				if (scan_le) begin
					before_q <= cand[TICK_W-1:0];
					idx_q    <= idx_q + 1'b1;
					pos_q    <= idx_q + 1'b1;
				end else begin
					pos_q <= idx_q;
				end
			end
			S_SH_WR:   i_q  <= i_q - 1'b1;
			S_INS_PUT: nd_q <= new_delta;
			S_POP: begin
				if (rcnt_q == '0)
					rs_st_q <= ST_EMPTY;
			end
			S_POP2: begin
				rs_rv_q  <= 1'b1;
				rs_tag_q <= frd_q.tag;
				tag_q    <= frd_q.tag;
				dly_q    <= frd_q.period;
				per_q    <= frd_q.period;
			end
			S_DONE: begin
				if (out_free) begin
					o_st_q  <= rs_st_q;
					o_rv_q  <= rs_rv_q;
					o_tag_q <= rs_tag_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LW'(TABLE_DEPTH))
		else $error("table count above depth");
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(SW'(cnt_q) + SW'(rcnt_q)) <= SW'(CAP))
		else $error("table plus fifo above capacity");
	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && o_rv_q) |-> (o_st_q == ST_OK))
		else $error("released task with bad status");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready)
		else $error("ready while busy");
`endif

endmodule

FILE: tb/tb_sched_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sched_scoreboard
// Timer list predictor and response checker for the delta-list scheduler.
// ----------------------------------------------------------------------------
package tb_sched_sb_pkg;
	import dlts_pkg::*;

	class sched_scoreboard;
		localparam int TDEPTH = 16;
		localparam int RDEPTH = 16;
		localparam int CAP = (TDEPTH < RDEPTH) ? TDEPTH : RDEPTH;

		// pending timer list
		bit [31:0] list_delta[TDEPTH];
		bit [31:0] list_period[TDEPTH];
		bit [7:0]  list_tag[TDEPTH];
		int        list_cnt;
		bit        due;
		// ready queue
		bit [7:0]  run_q_tag[$];
		bit [31:0] run_q_period[$];

		// expected responses
		bit [1:0]  exp_status[$];
		bit        exp_run[$];
		bit [7:0]  exp_tag[$];

		int        errors;
		int        n_full, n_empty, n_run;

		function new();
			list_cnt = 0;
			due = 0;
			errors = 0;
			n_full = 0;
			n_empty = 0;
			n_run = 0;
		endfunction

		function bit insert_task(bit [7:0] tag, bit [31:0] delay, bit [31:0] period);
			longint unsigned acc;
			int pos;
			bit [31:0] d;
			acc = 0;
			pos = 0;
			if (list_cnt + run_q_tag.size() >= CAP || list_cnt >= TDEPTH)
				return 0;
			while (pos < list_cnt && acc + list_delta[pos] <= delay) begin
				acc += list_delta[pos];
				pos++;
			end
			d = delay - acc[31:0];
			for (int i = list_cnt; i > pos; i--) begin
				list_delta[i] = list_delta[i-1];
				list_period[i] = list_period[i-1];
				list_tag[i] = list_tag[i-1];
			end
			list_delta[pos] = d;
			list_period[pos] = period;
			list_tag[pos] = tag;
			list_cnt++;
			if (pos + 1 < list_cnt)
				list_delta[pos+1] -= d;
			if (pos == 0)
				due = 0;
			return 1;
		endfunction

		function void release_head();
			if (list_cnt == 0 || run_q_tag.size() >= RDEPTH)
				return;
			run_q_tag.push_back(list_tag[0]);
			run_q_period.push_back(list_period[0]);
			for (int i = 0; i + 1 < list_cnt; i++) begin
				list_delta[i] = list_delta[i+1];
				list_period[i] = list_period[i+1];
				list_tag[i] = list_tag[i+1];
			end
			list_cnt--;
		endfunction

		// note an accepted request beat
		function void note_request(opcode_t op, bit [7:0] tag, bit [31:0] delay,
				bit [31:0] period);
			bit [1:0] st;
			bit rv;
			bit [7:0] rt;
			bit [31:0] p;
			st = ST_OK;
			rv = 0;
			rt = 0;
			case (op)
				OP_ADD: begin
					if (!insert_task(tag, delay, period)) begin
						st = ST_FULL;
						n_full++;
					end
				end
				OP_TICK: begin
					if (list_cnt > 0) begin
						if (list_delta[0] > 0)
							list_delta[0]--;
						if (list_delta[0] == 0)
							due = 1;
					end
				end
				OP_DISPATCH: begin
					if (due && list_cnt > 0) begin
						release_head();
						while (list_cnt > 0 && list_delta[0] == 0
								&& run_q_tag.size() < RDEPTH)
							release_head();
					end
					due = 0;
					if (run_q_tag.size() == 0) begin
						st = ST_EMPTY;
						n_empty++;
					end else begin
						rt = run_q_tag.pop_front();
						p = run_q_period.pop_front();
						rv = 1;
						n_run++;
						if (p != 0)
							void'(insert_task(rt, p, p));
					end
				end
				default: ;
			endcase
			exp_status.push_back(st);
			exp_run.push_back(rv);
			exp_tag.push_back(rt);
		endfunction

		// compare a response beat with the oldest expectation
		function void check_response(bit [1:0] st, bit rv, bit [7:0] rt);
			bit [1:0] es;
			bit er;
			bit [7:0] et;
			if (exp_status.size() == 0) begin
				$error("unexpected response beat: status %0d run_valid %0d run_tag %0d",
					st, rv, rt);
				errors++;
				return;
			end
			es = exp_status.pop_front();
			er = exp_run.pop_front();
			et = exp_tag.pop_front();
			if (st !== es) begin
				$error("status: expected %0d, actual %0d", es, st);
				errors++;
			end
			if (rv !== er) begin
				$error("run_valid: expected %0d, actual %0d", er, rv);
				errors++;
			end
			if (rt !== et) begin
				$error("run_tag: expected %0d, actual %0d", et, rt);
				errors++;
			end
		endfunction

		function int pending();
			return exp_status.size();
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed timer operations into the scheduler and checks
// every response against a cycle-free model of the timer list.
// ----------------------------------------------------------------------------
module tb_top;
	import dlts_pkg::*;
	import tb_sched_sb_pkg::*;

	localparam int RAND_ITEMS = 1600;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	bit   quiet_src;
	bit   quiet_snk;
	bit   hold_off;
	bit   src_done;
	int   idle_cycles;

	dlts_req_if req ();
	dlts_rsp_if rsp ();

	sched_scoreboard sb;

	delta_list_task_scheduler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// clock and reset
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		req.valid = 0;
		req.opcode = OP_NONE;
		req.task_tag = 0;
		req.delay_ticks = 0;
		req.period_ticks = 0;
		rsp.ready = 0;
		sb = new();
	end

	// one request beat, with random idle cycles before it
	task automatic send_op(opcode_t op, bit [7:0] tag, bit [31:0] delay,
			bit [31:0] period);
		while (!quiet_src && $urandom_range(99) < 35) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.opcode <= op;
		req.task_tag <= tag;
		req.delay_ticks <= delay;
		req.period_ticks <= period;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(op, tag, delay, period);
	endtask

	function automatic bit [31:0] rand_delay();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return 0;
			default: return $urandom_range(12);
		endcase
	endfunction

	task automatic random_op();
		int r;
		bit [31:0] p;
		r = $urandom_range(99);
		p = ($urandom_range(3) == 0) ? $urandom_range(8) : 0;
		if ($urandom_range(19) == 0)
			p = $urandom;
		if (r < 35)
			send_op(OP_ADD, 8'($urandom), rand_delay(), p);
		else if (r < 70)
			send_op(OP_TICK, 8'($urandom), $urandom, $urandom);
		else if (r < 97)
			send_op(OP_DISPATCH, 8'($urandom), $urandom, $urandom);
		else
			send_op(OP_NONE, 8'($urandom), $urandom, $urandom);
	endtask

	// stimulus
	initial begin
		src_done = 0;
		quiet_src = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: empty dispatch, tick on empty list, unused opcode
		send_op(OP_DISPATCH, 0, 0, 0);
		send_op(OP_TICK, 0, 0, 0);
		send_op(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// extremes of delay and ties at equal due time
		send_op(OP_ADD, 8'h00, 0, 0);
		send_op(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_ADD, 8'hA5, 0, 3);
		send_op(OP_ADD, 8'h5A, 2, 0);
		send_op(OP_ADD, 8'h3C, 2, 1);
		send_op(OP_TICK, 0, 0, 0);
		send_op(OP_DISPATCH, 0, 0, 0);
		send_op(OP_DISPATCH, 0, 0, 0);
		send_op(OP_TICK, 0, 0, 0);
		send_op(OP_TICK, 0, 0, 0);
		send_op(OP_DISPATCH, 0, 0, 0);
		// fill the table until adds are rejected
		for (int i = 0; i < 14; i++)
			send_op(OP_ADD, 8'(i), 32'(i), 0);
		for (int i = 0; i < 4; i++)
			send_op(OP_DISPATCH, 0, 0, 0);
		// random part, with a stretch of back-to-back beats
		for (int i = 0; i < RAND_ITEMS; i++) begin
			quiet_src = (i >= 300 && i < 500);
			random_op();
		end
		req.valid <= 0;
		quiet_src = 0;
		src_done = 1;
	end

	// response side, with one long hold-off
	initial begin
		quiet_snk = 0;
		hold_off = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				sb.check_response(rsp.status, rsp.run_valid, rsp.run_tag);
			if (sb.n_run == 40 && !hold_off) begin
				hold_off = 1;
				rsp.ready <= 0;
				repeat (400) @(posedge clk);
			end
			quiet_snk = (sb.n_run > 150 && sb.n_run < 220);
			rsp.ready <= quiet_snk || ($urandom_range(99) >= 35);
		end
	end

	// watchdog and end of run
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("** delta_list_task_scheduler_core: FAILED **");
				$finish;
			end
			if (src_done && sb.pending() == 0) begin
				repeat (100) @(posedge clk);
				if (rsp.valid) begin
					$error("response beat offered with nothing expected");
					sb.errors++;
				end
				$display("ran %0d tasks, %0d rejected adds, %0d empty dispatches",
					sb.n_run, sb.n_full, sb.n_empty);
				if (sb.errors == 0)
					$display("** delta_list_task_scheduler_core: PASSED **");
				else
					$display("** delta_list_task_scheduler_core: FAILED **");
				$finish;
			end
		end
	end
endmodule

FILE: delta_list_task_scheduler_core.f
rtl/core/dlts_pkg.sv
rtl/core/dlts_req_if.sv
rtl/core/dlts_rsp_if.sv
rtl/core/delta_list_task_scheduler_core.sv
tb/tb_sched_scoreboard.sv
tb/tb_top.sv
